/* src/rigid_body_state_predict_defines.svh */
// Assertion macros shared by the rigid-body state predictor RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RIGID_BODY_STATE_PREDICT_DEFINES_SVH
`define RIGID_BODY_STATE_PREDICT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rbsp_pkg.sv */
// Package for the rigid-body state predictor: payload types, scratch memory map,
// controller states, datapath commands and the prediction micro-program.
// No dependencies.
package rbsp_pkg;

  localparam int NSTATE    = 13;
  localparam int MEM_DEPTH = 48;
  localparam int CFG_NUM   = 8;
  localparam int ADDR_W    = 6;
  localparam int PC_W      = 8;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic              req_type;
    logic [3:0]        element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic [15:0]       step_time;
    logic [4:0]        status_flags;
  } req_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               out_last;
  } res_t;

  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_WRITE   = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INV_MASS = 3'd0;
  localparam logic [2:0] CFG_GRAVITY  = 3'd1;
  localparam logic [2:0] CFG_IIX      = 3'd2;
  localparam logic [2:0] CFG_IIY      = 3'd3;
  localparam logic [2:0] CFG_IIZ      = 3'd4;
  localparam logic [2:0] CFG_GCX      = 3'd5;
  localparam logic [2:0] CFG_GCY      = 3'd6;
  localparam logic [2:0] CFG_GCZ      = 3'd7;

  localparam logic signed [31:0] CFG_RESET [CFG_NUM] = '{
    32'sd65536, -32'sd642908, 32'sd65536, 32'sd65536, 32'sd65536,
    32'sd0, 32'sd0, 32'sd0
  };

  // Operand space: scratch memory below MEM_DEPTH, registers above.
  localparam addr_t A_WX  = 6'd0;
  localparam addr_t A_WY  = 6'd1;
  localparam addr_t A_WZ  = 6'd2;
  localparam addr_t A_Q0  = 6'd3;
  localparam addr_t A_Q1  = 6'd4;
  localparam addr_t A_Q2  = 6'd5;
  localparam addr_t A_Q3  = 6'd6;
  localparam addr_t A_PX  = 6'd7;
  localparam addr_t A_PY  = 6'd8;
  localparam addr_t A_PZ  = 6'd9;
  localparam addr_t A_VX  = 6'd10;
  localparam addr_t A_VY  = 6'd11;
  localparam addr_t A_VZ  = 6'd12;
  localparam addr_t A_NEW = 6'd13;
  localparam addr_t A_N0  = 6'd13;
  localparam addr_t A_N1  = 6'd14;
  localparam addr_t A_N2  = 6'd15;
  localparam addr_t A_N3  = 6'd16;
  localparam addr_t A_N4  = 6'd17;
  localparam addr_t A_N5  = 6'd18;
  localparam addr_t A_N6  = 6'd19;
  localparam addr_t A_N7  = 6'd20;
  localparam addr_t A_N8  = 6'd21;
  localparam addr_t A_N9  = 6'd22;
  localparam addr_t A_N10 = 6'd23;
  localparam addr_t A_N11 = 6'd24;
  localparam addr_t A_N12 = 6'd25;
  localparam addr_t A_T0  = 6'd26;
  localparam addr_t A_T1  = 6'd27;
  localparam addr_t A_P00 = 6'd28;
  localparam addr_t A_P11 = 6'd29;
  localparam addr_t A_P22 = 6'd30;
  localparam addr_t A_P33 = 6'd31;
  localparam addr_t A_P01 = 6'd32;
  localparam addr_t A_P02 = 6'd33;
  localparam addr_t A_P03 = 6'd34;
  localparam addr_t A_P12 = 6'd35;
  localparam addr_t A_P13 = 6'd36;
  localparam addr_t A_P23 = 6'd37;
  localparam addr_t A_R00 = 6'd38;
  localparam addr_t A_R01 = 6'd39;
  localparam addr_t A_R02 = 6'd40;
  localparam addr_t A_R10 = 6'd41;
  localparam addr_t A_R11 = 6'd42;
  localparam addr_t A_R12 = 6'd43;
  localparam addr_t A_R20 = 6'd44;
  localparam addr_t A_R21 = 6'd45;
  localparam addr_t A_R22 = 6'd46;
  // Body velocity and acceleration reuse quaternion product slots.
  localparam addr_t A_VB0 = 6'd28;
  localparam addr_t A_VB1 = 6'd29;
  localparam addr_t A_VB2 = 6'd30;
  localparam addr_t A_AC0 = 6'd31;
  localparam addr_t A_AC1 = 6'd32;
  localparam addr_t A_AC2 = 6'd33;
  localparam addr_t A_INVM = 6'd48;
  localparam addr_t A_GRAV = 6'd49;
  localparam addr_t A_IIX  = 6'd50;
  localparam addr_t A_IIY  = 6'd51;
  localparam addr_t A_IIZ  = 6'd52;
  localparam addr_t A_GCX  = 6'd53;
  localparam addr_t A_GCY  = 6'd54;
  localparam addr_t A_GCZ  = 6'd55;
  localparam addr_t A_FX   = 6'd56;
  localparam addr_t A_FY   = 6'd57;
  localparam addr_t A_FZ   = 6'd58;
  localparam addr_t A_TX   = 6'd59;
  localparam addr_t A_TY   = 6'd60;
  localparam addr_t A_TZ   = 6'd61;
  localparam addr_t A_DT   = 6'd62;
  localparam addr_t A_ZERO = 6'd63;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL16,
    OP_MUL17
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CALC,
    S_WB,
    S_ORD,
    S_OSHOW
  } state_t;

  typedef struct packed {
    op_t   op;
    addr_t dst;
    addr_t a;
    addr_t b;
    logic  last;
  } uop_t;

  typedef struct packed {
    logic       rd_en;
    logic       rd_out;
    logic       calc;
    logic       wb;
    logic       req_wr;
    logic       load;
    logic       out_wb;
    op_t        op;
    addr_t      dst;
    addr_t      a;
    addr_t      b;
    logic [3:0] out_k;
  } cmd_t;

  function automatic uop_t mk(input op_t op, input addr_t d, input addr_t a, input addr_t b);
    uop_t u;
    u.op   = op;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    u.last = 1'b0;
    return u;
  endfunction

  // One saturating operation per word; the run ends on the word marked last.
  function automatic uop_t uprog(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // Body rates.
      8'd0:   u = mk(OP_MUL16, A_T0, A_TX, A_IIX);
      8'd1:   u = mk(OP_MUL16, A_T1, A_WY, A_WZ);
      8'd2:   u = mk(OP_MUL16, A_T1, A_T1, A_GCX);
      8'd3:   u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd4:   u = mk(OP_MUL16, A_T0, A_DT, A_T0);
      8'd5:   u = mk(OP_ADD,   A_N0, A_WX, A_T0);
      8'd6:   u = mk(OP_MUL16, A_T0, A_TY, A_IIY);
      8'd7:   u = mk(OP_MUL16, A_T1, A_WZ, A_WX);
      8'd8:   u = mk(OP_MUL16, A_T1, A_T1, A_GCY);
      8'd9:   u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd10:  u = mk(OP_MUL16, A_T0, A_DT, A_T0);
      8'd11:  u = mk(OP_ADD,   A_N1, A_WY, A_T0);
      8'd12:  u = mk(OP_MUL16, A_T0, A_TZ, A_IIZ);
      8'd13:  u = mk(OP_MUL16, A_T1, A_WX, A_WY);
      8'd14:  u = mk(OP_MUL16, A_T1, A_T1, A_GCZ);
      8'd15:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd16:  u = mk(OP_MUL16, A_T0, A_DT, A_T0);
      8'd17:  u = mk(OP_ADD,   A_N2, A_WZ, A_T0);
      // Quaternion kinematics.
      8'd18:  u = mk(OP_MUL16, A_T0, A_WX, A_Q1);
      8'd19:  u = mk(OP_SUB,   A_T0, A_ZERO, A_T0);
      8'd20:  u = mk(OP_MUL16, A_T1, A_WY, A_Q2);
      8'd21:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd22:  u = mk(OP_MUL16, A_T1, A_WZ, A_Q3);
      8'd23:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd24:  u = mk(OP_MUL17, A_T0, A_DT, A_T0);
      8'd25:  u = mk(OP_ADD,   A_N3, A_Q0, A_T0);
      8'd26:  u = mk(OP_MUL16, A_T0, A_WX, A_Q0);
      8'd27:  u = mk(OP_MUL16, A_T1, A_WZ, A_Q2);
      8'd28:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd29:  u = mk(OP_MUL16, A_T1, A_WY, A_Q3);
      8'd30:  u = mk(OP_ADD,   A_T0, A_T0, A_T1);
      8'd31:  u = mk(OP_MUL17, A_T0, A_DT, A_T0);
      8'd32:  u = mk(OP_ADD,   A_N4, A_Q1, A_T0);
      8'd33:  u = mk(OP_MUL16, A_T0, A_WY, A_Q0);
      8'd34:  u = mk(OP_MUL16, A_T1, A_WZ, A_Q1);
      8'd35:  u = mk(OP_ADD,   A_T0, A_T0, A_T1);
      8'd36:  u = mk(OP_MUL16, A_T1, A_WX, A_Q3);
      8'd37:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd38:  u = mk(OP_MUL17, A_T0, A_DT, A_T0);
      8'd39:  u = mk(OP_ADD,   A_N5, A_Q2, A_T0);
      8'd40:  u = mk(OP_MUL16, A_T0, A_WZ, A_Q0);
      8'd41:  u = mk(OP_MUL16, A_T1, A_WY, A_Q1);
      8'd42:  u = mk(OP_SUB,   A_T0, A_T0, A_T1);
      8'd43:  u = mk(OP_MUL16, A_T1, A_WX, A_Q2);
      8'd44:  u = mk(OP_ADD,   A_T0, A_T0, A_T1);
      8'd45:  u = mk(OP_MUL17, A_T0, A_DT, A_T0);
      8'd46:  u = mk(OP_ADD,   A_N6, A_Q3, A_T0);
      // Quaternion products.
      8'd47:  u = mk(OP_MUL16, A_P00, A_Q0, A_Q0);
      8'd48:  u = mk(OP_MUL16, A_P11, A_Q1, A_Q1);
      8'd49:  u = mk(OP_MUL16, A_P22, A_Q2, A_Q2);
      8'd50:  u = mk(OP_MUL16, A_P33, A_Q3, A_Q3);
      8'd51:  u = mk(OP_MUL16, A_P01, A_Q0, A_Q1);
      8'd52:  u = mk(OP_MUL16, A_P02, A_Q0, A_Q2);
      8'd53:  u = mk(OP_MUL16, A_P03, A_Q0, A_Q3);
      8'd54:  u = mk(OP_MUL16, A_P12, A_Q1, A_Q2);
      8'd55:  u = mk(OP_MUL16, A_P13, A_Q1, A_Q3);
      8'd56:  u = mk(OP_MUL16, A_P23, A_Q2, A_Q3);
      // Rotation matrix.
      8'd57:  u = mk(OP_ADD,   A_R00, A_P00, A_P11);
      8'd58:  u = mk(OP_SUB,   A_R00, A_R00, A_P22);
      8'd59:  u = mk(OP_SUB,   A_R00, A_R00, A_P33);
      8'd60:  u = mk(OP_SUB,   A_R01, A_P12, A_P03);
      8'd61:  u = mk(OP_ADD,   A_R01, A_R01, A_R01);
      8'd62:  u = mk(OP_ADD,   A_R02, A_P13, A_P02);
      8'd63:  u = mk(OP_ADD,   A_R02, A_R02, A_R02);
      8'd64:  u = mk(OP_ADD,   A_R10, A_P12, A_P03);
      8'd65:  u = mk(OP_ADD,   A_R10, A_R10, A_R10);
      8'd66:  u = mk(OP_SUB,   A_R11, A_P00, A_P11);
      8'd67:  u = mk(OP_ADD,   A_R11, A_R11, A_P22);
      8'd68:  u = mk(OP_SUB,   A_R11, A_R11, A_P33);
      8'd69:  u = mk(OP_SUB,   A_R12, A_P23, A_P01);
      8'd70:  u = mk(OP_ADD,   A_R12, A_R12, A_R12);
      8'd71:  u = mk(OP_SUB,   A_R20, A_P13, A_P02);
      8'd72:  u = mk(OP_ADD,   A_R20, A_R20, A_R20);
      8'd73:  u = mk(OP_ADD,   A_R21, A_P23, A_P01);
      8'd74:  u = mk(OP_ADD,   A_R21, A_R21, A_R21);
      8'd75:  u = mk(OP_SUB,   A_R22, A_P00, A_P11);
      8'd76:  u = mk(OP_SUB,   A_R22, A_R22, A_P22);
      8'd77:  u = mk(OP_ADD,   A_R22, A_R22, A_P33);
      // Body-frame velocity.
      8'd78:  u = mk(OP_MUL16, A_VB0, A_R00, A_VX);
      8'd79:  u = mk(OP_MUL16, A_T0,  A_R10, A_VY);
      8'd80:  u = mk(OP_ADD,   A_VB0, A_VB0, A_T0);
      8'd81:  u = mk(OP_MUL16, A_T0,  A_R20, A_VZ);
      8'd82:  u = mk(OP_ADD,   A_VB0, A_VB0, A_T0);
      8'd83:  u = mk(OP_MUL16, A_VB1, A_R01, A_VX);
      8'd84:  u = mk(OP_MUL16, A_T0,  A_R11, A_VY);
      8'd85:  u = mk(OP_ADD,   A_VB1, A_VB1, A_T0);
      8'd86:  u = mk(OP_MUL16, A_T0,  A_R21, A_VZ);
      8'd87:  u = mk(OP_ADD,   A_VB1, A_VB1, A_T0);
      8'd88:  u = mk(OP_MUL16, A_VB2, A_R02, A_VX);
      8'd89:  u = mk(OP_MUL16, A_T0,  A_R12, A_VY);
      8'd90:  u = mk(OP_ADD,   A_VB2, A_VB2, A_T0);
      8'd91:  u = mk(OP_MUL16, A_T0,  A_R22, A_VZ);
      8'd92:  u = mk(OP_ADD,   A_VB2, A_VB2, A_T0);
      // Rotated force scaled by reciprocal mass.
      8'd93:  u = mk(OP_MUL16, A_AC0, A_R00, A_FX);
      8'd94:  u = mk(OP_MUL16, A_T0,  A_R01, A_FY);
      8'd95:  u = mk(OP_ADD,   A_AC0, A_AC0, A_T0);
      8'd96:  u = mk(OP_MUL16, A_T0,  A_R02, A_FZ);
      8'd97:  u = mk(OP_ADD,   A_AC0, A_AC0, A_T0);
      8'd98:  u = mk(OP_MUL16, A_AC0, A_AC0, A_INVM);
      8'd99:  u = mk(OP_MUL16, A_AC1, A_R10, A_FX);
      8'd100: u = mk(OP_MUL16, A_T0,  A_R11, A_FY);
      8'd101: u = mk(OP_ADD,   A_AC1, A_AC1, A_T0);
      8'd102: u = mk(OP_MUL16, A_T0,  A_R12, A_FZ);
      8'd103: u = mk(OP_ADD,   A_AC1, A_AC1, A_T0);
      8'd104: u = mk(OP_MUL16, A_AC1, A_AC1, A_INVM);
      8'd105: u = mk(OP_MUL16, A_AC2, A_R20, A_FX);
      8'd106: u = mk(OP_MUL16, A_T0,  A_R21, A_FY);
      8'd107: u = mk(OP_ADD,   A_AC2, A_AC2, A_T0);
      8'd108: u = mk(OP_MUL16, A_T0,  A_R22, A_FZ);
      8'd109: u = mk(OP_ADD,   A_AC2, A_AC2, A_T0);
      8'd110: u = mk(OP_MUL16, A_AC2, A_AC2, A_INVM);
      // Cross-product terms and gravity.
      8'd111: u = mk(OP_MUL16, A_T0,  A_VB1, A_WZ);
      8'd112: u = mk(OP_ADD,   A_AC0, A_AC0, A_T0);
      8'd113: u = mk(OP_MUL16, A_T0,  A_VB2, A_WY);
      8'd114: u = mk(OP_SUB,   A_AC0, A_AC0, A_T0);
      8'd115: u = mk(OP_MUL16, A_T0,  A_VB2, A_WX);
      8'd116: u = mk(OP_ADD,   A_AC1, A_AC1, A_T0);
      8'd117: u = mk(OP_MUL16, A_T0,  A_VB0, A_WZ);
      8'd118: u = mk(OP_SUB,   A_AC1, A_AC1, A_T0);
      8'd119: u = mk(OP_MUL16, A_T0,  A_VB0, A_WY);
      8'd120: u = mk(OP_ADD,   A_AC2, A_AC2, A_T0);
      8'd121: u = mk(OP_MUL16, A_T0,  A_VB1, A_WX);
      8'd122: u = mk(OP_SUB,   A_AC2, A_AC2, A_T0);
      8'd123: u = mk(OP_ADD,   A_AC2, A_AC2, A_GRAV);
      // Velocity and position candidates.
      8'd124: u = mk(OP_MUL16, A_T0,  A_DT, A_AC0);
      8'd125: u = mk(OP_ADD,   A_N10, A_VX, A_T0);
      8'd126: u = mk(OP_MUL16, A_T0,  A_DT, A_AC1);
      8'd127: u = mk(OP_ADD,   A_N11, A_VY, A_T0);
      8'd128: u = mk(OP_MUL16, A_T0,  A_DT, A_AC2);
      8'd129: u = mk(OP_ADD,   A_N12, A_VZ, A_T0);
      8'd130: u = mk(OP_MUL16, A_T0,  A_DT, A_VX);
      8'd131: u = mk(OP_ADD,   A_N7,  A_PX, A_T0);
      8'd132: u = mk(OP_MUL16, A_T0,  A_DT, A_VY);
      8'd133: u = mk(OP_ADD,   A_N8,  A_PY, A_T0);
      8'd134: u = mk(OP_MUL16, A_T0,  A_DT, A_VZ);
      8'd135: begin
        u = mk(OP_ADD, A_N9, A_PZ, A_T0);
        u.last = 1'b1;
      end
      default: begin
        u = mk(OP_ADD, A_T0, A_ZERO, A_ZERO);
        u.last = 1'b1;
      end
    endcase
    return u;
  endfunction

endpackage

/* src/rbsp_dpath.sv */
// Datapath of the rigid-body state predictor: scratch memory holding state and
// intermediates, configuration and input registers, one shared multiplier and adder.
// Depends on rbsp_pkg.
module rbsp_dpath import rbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  input  req_t              req,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic signed [31:0] cfg_data,
  output res_t              res
);

  logic signed [31:0] mem [MEM_DEPTH];
  logic [NSTATE-1:0]  valid;

  logic signed [31:0] cfg_reg [CFG_NUM];
  logic signed [31:0] frc [3];
  logic signed [31:0] trq [3];
  logic [15:0]        dt;
  logic [3:0]         flg;

  logic signed [31:0] rdata_a;
  logic signed [31:0] rdata_b;
  logic signed [63:0] prod;
  logic signed [32:0] sum;

  addr_t              addr_a;
  addr_t              out_addr;
  logic               out_new;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] shifted;
  logic signed [31:0] wb_val;

  function automatic logic signed [31:0] sel_src(input addr_t code,
                                                 input logic signed [31:0] md);
    logic signed [31:0] v;
    case (code)
      A_INVM:  v = cfg_reg[CFG_INV_MASS];
      A_GRAV:  v = cfg_reg[CFG_GRAVITY];
      A_IIX:   v = cfg_reg[CFG_IIX];
      A_IIY:   v = cfg_reg[CFG_IIY];
      A_IIZ:   v = cfg_reg[CFG_IIZ];
      A_GCX:   v = cfg_reg[CFG_GCX];
      A_GCY:   v = cfg_reg[CFG_GCY];
      A_GCZ:   v = cfg_reg[CFG_GCZ];
      A_FX:    v = frc[0];
      A_FY:    v = frc[1];
      A_FZ:    v = frc[2];
      A_TX:    v = trq[0];
      A_TY:    v = trq[1];
      A_TZ:    v = trq[2];
      A_DT:    v = signed'({16'b0, dt});
      A_ZERO:  v = '0;
      default: v = md;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_NUM; i++) cfg_reg[i] <= CFG_RESET[i];
    end else if (cfg_we) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  // Flags are closed on load: position implies velocity, xy velocity and
  // roll-pitch imply each other, so only four bits are kept.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frc[0] <= req.force_x;
      frc[1] <= req.force_y;
      frc[2] <= req.force_z;
      trq[0] <= req.torque_x;
      trq[1] <= req.torque_y;
      trq[2] <= req.torque_z;
      dt     <= req.step_time;
      flg[0] <= req.status_flags[0];
      flg[1] <= req.status_flags[1];
      flg[2] <= req.status_flags[2] | req.status_flags[0] | req.status_flags[4];
      flg[3] <= req.status_flags[3] | req.status_flags[1];
    end
  end

  // Elements 0 to 6 always take the new value; the rest follow the flags.
  always_comb begin
    case (cmd.out_k)
      4'd7, 4'd8:   out_new = flg[0];
      4'd9:         out_new = flg[1];
      4'd10, 4'd11: out_new = flg[2];
      4'd12:        out_new = flg[3];
      default:      out_new = 1'b1;
    endcase
    out_addr = out_new ? A_NEW + addr_t'(cmd.out_k) : addr_t'(cmd.out_k);
    addr_a   = cmd.rd_out ? out_addr : cmd.a;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      if (addr_a >= addr_t'(MEM_DEPTH)) begin
        rdata_a <= '0;
      end else if (addr_a < addr_t'(NSTATE) && !valid[addr_a[3:0]]) begin
        rdata_a <= '0;
      end else begin
        rdata_a <= mem[addr_a];
      end
      if (cmd.b >= addr_t'(MEM_DEPTH)) begin
        rdata_b <= '0;
      end else if (cmd.b < addr_t'(NSTATE) && !valid[cmd.b[3:0]]) begin
        rdata_b <= '0;
      end else begin
        rdata_b <= mem[cmd.b];
      end
    end
  end

  always_comb begin
    opa = sel_src(cmd.a, rdata_a);
    opb = sel_src(cmd.b, rdata_b);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      prod <= opa * opb;
      if (cmd.op == OP_SUB) begin
        sum <= signed'({opa[31], opa}) - signed'({opb[31], opb});
      end else begin
        sum <= signed'({opa[31], opa}) + signed'({opb[31], opb});
      end
    end
  end

  // Arithmetic shift gives the floor of the scaled product.
  always_comb begin
    shifted = (cmd.op == OP_MUL17) ? (prod >>> 17) : (prod >>> 16);
    case (cmd.op)
      OP_MUL16, OP_MUL17: begin
        if (shifted > 64'sd2147483647) begin
          wb_val = 32'sh7fffffff;
        end else if (shifted < -64'sd2147483648) begin
          wb_val = 32'sh80000000;
        end else begin
          wb_val = shifted[31:0];
        end
      end
      default: begin
        if (sum[32] != sum[31]) begin
          wb_val = sum[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          wb_val = sum[31:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.req_wr && req.element_index < 4'(NSTATE)) begin
      mem[addr_t'(req.element_index)] <= req.element_value;
    end else if (cmd.wb) begin
      mem[cmd.dst] <= wb_val;
    end else if (cmd.out_wb) begin
      mem[addr_t'(cmd.out_k)] <= rdata_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.req_wr && req.element_index < 4'(NSTATE)) begin
      valid[req.element_index] <= 1'b1;
    end else if (cmd.out_wb) begin
      valid[cmd.out_k] <= 1'b1;
    end
  end

  assign res.out_index = cmd.out_k;
  assign res.out_value = rdata_a;
  assign res.out_last  = (cmd.out_k == 4'(NSTATE - 1));

endmodule

/* src/rbsp_ctrl.sv */
// Controller of the rigid-body state predictor: request handshake, micro-program
// sequencing and the output run of thirteen elements.
// Depends on rbsp_pkg and rigid_body_state_predict_defines.svh.
`include "rigid_body_state_predict_defines.svh"

module rbsp_ctrl import rbsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_type,
  output logic req_stall,
  output logic res_valid,
  input  logic res_stall,
  output cmd_t cmd
);

  localparam logic [3:0] LAST_IDX = 4'(NSTATE - 1);

  state_t          state;
  state_t          state_next;
  logic [PC_W-1:0] pc;
  logic [3:0]      k;
  uop_t            uop;
  logic            req_acc;
  logic            res_acc;

  assign uop     = uprog(pc);
  assign req_acc = req_valid && (state == S_IDLE);
  assign res_acc = res_valid && !res_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (req_acc && req_type == REQ_PREDICT) state_next = S_RD;
      S_RD:    state_next = S_CALC;
      S_CALC:  state_next = S_WB;
      S_WB:    state_next = uop.last ? S_ORD : S_RD;
      S_ORD:   state_next = S_OSHOW;
      S_OSHOW: if (res_acc) state_next = (k == LAST_IDX) ? S_IDLE : S_ORD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = (state != S_IDLE);
    res_valid  = (state == S_OSHOW);
    cmd        = '0;
    cmd.op     = uop.op;
    cmd.dst    = uop.dst;
    cmd.a      = uop.a;
    cmd.b      = uop.b;
    cmd.out_k  = k;
    unique case (state)
      S_IDLE: begin
        cmd.req_wr = req_acc && (req_type == REQ_WRITE);
        cmd.load   = req_acc && (req_type == REQ_PREDICT);
      end
      S_RD:    cmd.rd_en = 1'b1;
      S_CALC:  cmd.calc = 1'b1;
      S_WB:    cmd.wb = 1'b1;
      S_ORD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_out = 1'b1;
      end
      S_OSHOW: cmd.out_wb = !res_stall;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        pc <= '0;
        k  <= '0;
      end else begin
        if (state == S_WB) pc <= pc + 1'b1;
        if (state == S_OSHOW && res_acc) k <= k + 1'b1;
      end
    end
  end

  `RBSP_ASSERT_NOW(a_res_blocks_req, res_valid, req_stall, "result shown while requests open")
  `RBSP_ASSERT_NEXT(a_pred_start, req_valid && !req_stall && req_type == REQ_PREDICT, state == S_RD && pc == '0, "predict did not start at program top")
  `RBSP_ASSERT_NEXT(a_last_idle, res_valid && !res_stall && k == LAST_IDX, state == S_IDLE, "run did not end after last element")
  `RBSP_ASSERT_NEXT(a_wb_next, state == S_WB, state == S_RD || state == S_ORD, "bad step after write-back")

endmodule

/* src/rigid_body_state_predict.sv */
// Top level of the rigid-body state predictor: controller plus datapath.
// Depends on rbsp_pkg, rbsp_ctrl and rbsp_dpath.
//
//   channel  signals                     direction  accepted when
//   req      req_valid, req_stall, req   in         req_valid && !req_stall
//   res      res_valid, res_stall, res   out        res_valid && !res_stall
//   cfg      cfg_valid, cfg_ready,       in         cfg_valid && cfg_ready
//            cfg_index, cfg_data
//
// A write item is taken in the idle state and leaves req_stall low. A predict item
// runs 136 micro-operations, each a read, a calc and a write-back step, on the single
// shared multiplier and adder, then shows 13 result items, each a read and a show
// step; res_stall holds the show step. req_stall stays high until the last
// result item is taken. Reset is synchronous; it zeroes the state and loads
// the register defaults at once.
module rigid_body_state_predict import rbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic signed [31:0] cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  rbsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd)
  );

  rbsp_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

endmodule

/* bench/rigid_body_state_predict_tb.sv */
// Self-checking bench for the rigid-body state predictor: element writes,
// Euler predict steps and register writes, checked against an in-bench model.
// Depends on rbsp_pkg and the rigid_body_state_predict RTL.
module rigid_body_state_predict_tb import rbsp_pkg::*; ();

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic signed [31:0] cfg_data = '0;

  localparam int IDLE_LIMIT = 20000;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;

  always #5 clk = ~clk;

  rigid_body_state_predict uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic signed [31:0] state_mdl [NSTATE];
  logic signed [31:0] reg_mdl [CFG_NUM];
  res_t pending_elems [$];
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return MAXV;
    if (v < -66'sd2147483648) return MINV;
    return v[31:0];
  endfunction

  // Product with floor shift, then saturate.
  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
      input logic signed [31:0] b, input int sh);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clamp(p >>> sh);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
      input logic signed [31:0] b);
    return clamp(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
      input logic signed [31:0] b);
    return clamp(66'(a) - 66'(b));
  endfunction

  task automatic predict_step(input req_t it);
    logic signed [31:0] s [NSTATE];
    logic signed [31:0] n [NSTATE];
    logic signed [31:0] r [3][3];
    logic signed [31:0] f [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] acc [3];
    logic signed [31:0] dt, wx, wy, wz, q0, q1, q2, q3;
    logic signed [31:0] p00, p11, p22, p33, p01, p02, p03, p12, p13, p23;
    logic [4:0] fl;
    res_t e;
    if (it.req_type == REQ_WRITE) begin
      if (it.element_index < NSTATE) state_mdl[it.element_index] = it.element_value;
      return;
    end
    fl = it.status_flags;
    if (fl[0]) fl[2] = 1'b1;
    if (fl[1]) fl[3] = 1'b1;
    if (fl[2]) fl[4] = 1'b1;
    if (fl[4]) fl[2] = 1'b1;
    s = state_mdl;
    n = s;
    dt = {16'd0, it.step_time};
    f[0] = it.force_x; f[1] = it.force_y; f[2] = it.force_z;
    wx = s[0]; wy = s[1]; wz = s[2];
    q0 = s[3]; q1 = s[4]; q2 = s[5]; q3 = s[6];
    n[0] = qadd(wx, mulq(dt, qsub(mulq(it.torque_x, reg_mdl[CFG_IIX], 16),
        mulq(mulq(wy, wz, 16), reg_mdl[CFG_GCX], 16)), 16));
    n[1] = qadd(wy, mulq(dt, qsub(mulq(it.torque_y, reg_mdl[CFG_IIY], 16),
        mulq(mulq(wz, wx, 16), reg_mdl[CFG_GCY], 16)), 16));
    n[2] = qadd(wz, mulq(dt, qsub(mulq(it.torque_z, reg_mdl[CFG_IIZ], 16),
        mulq(mulq(wx, wy, 16), reg_mdl[CFG_GCZ], 16)), 16));
    n[3] = qadd(q0, mulq(dt, qsub(qsub(qsub(32'sd0, mulq(wx, q1, 16)),
        mulq(wy, q2, 16)), mulq(wz, q3, 16)), 17));
    n[4] = qadd(q1, mulq(dt, qadd(qsub(mulq(wx, q0, 16), mulq(wz, q2, 16)),
        mulq(wy, q3, 16)), 17));
    n[5] = qadd(q2, mulq(dt, qsub(qadd(mulq(wy, q0, 16), mulq(wz, q1, 16)),
        mulq(wx, q3, 16)), 17));
    n[6] = qadd(q3, mulq(dt, qadd(qsub(mulq(wz, q0, 16), mulq(wy, q1, 16)),
        mulq(wx, q2, 16)), 17));
    p00 = mulq(q0, q0, 16); p11 = mulq(q1, q1, 16);
    p22 = mulq(q2, q2, 16); p33 = mulq(q3, q3, 16);
    p01 = mulq(q0, q1, 16); p02 = mulq(q0, q2, 16); p03 = mulq(q0, q3, 16);
    p12 = mulq(q1, q2, 16); p13 = mulq(q1, q3, 16); p23 = mulq(q2, q3, 16);
    r[0][0] = qsub(qsub(qadd(p00, p11), p22), p33);
    r[0][1] = qadd(qsub(p12, p03), qsub(p12, p03));
    r[0][2] = qadd(qadd(p13, p02), qadd(p13, p02));
    r[1][0] = qadd(qadd(p12, p03), qadd(p12, p03));
    r[1][1] = qsub(qadd(qsub(p00, p11), p22), p33);
    r[1][2] = qadd(qsub(p23, p01), qsub(p23, p01));
    r[2][0] = qadd(qsub(p13, p02), qsub(p13, p02));
    r[2][1] = qadd(qadd(p23, p01), qadd(p23, p01));
    r[2][2] = qadd(qsub(qsub(p00, p11), p22), p33);
    for (int i = 0; i < 3; i++) begin
      vb[i] = qadd(qadd(mulq(r[0][i], s[10], 16), mulq(r[1][i], s[11], 16)),
          mulq(r[2][i], s[12], 16));
      acc[i] = mulq(qadd(qadd(mulq(r[i][0], f[0], 16), mulq(r[i][1], f[1], 16)),
          mulq(r[i][2], f[2], 16)), reg_mdl[CFG_INV_MASS], 16);
    end
    acc[0] = qsub(qadd(acc[0], mulq(vb[1], wz, 16)), mulq(vb[2], wy, 16));
    acc[1] = qsub(qadd(acc[1], mulq(vb[2], wx, 16)), mulq(vb[0], wz, 16));
    acc[2] = qadd(qsub(qadd(acc[2], mulq(vb[0], wy, 16)), mulq(vb[1], wx, 16)),
        reg_mdl[CFG_GRAVITY]);
    if (fl[2]) begin
      n[10] = qadd(s[10], mulq(dt, acc[0], 16));
      n[11] = qadd(s[11], mulq(dt, acc[1], 16));
    end
    if (fl[3]) n[12] = qadd(s[12], mulq(dt, acc[2], 16));
    if (fl[0]) begin
      n[7] = qadd(s[7], mulq(dt, s[10], 16));
      n[8] = qadd(s[8], mulq(dt, s[11], 16));
    end
    if (fl[1]) n[9] = qadd(s[9], mulq(dt, s[12], 16));
    state_mdl = n;
    for (int k = 0; k < NSTATE; k++) begin
      e.out_index = 4'(k);
      e.out_value = n[k];
      e.out_last = (k == NSTATE - 1);
      pending_elems.push_back(e);
    end
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      3: return 32'($signed($urandom_range(0, 8388608)) - 4194304);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_item();
    req_t it;
    it = '0;
    it.req_type = ($urandom_range(0, 2) == 0) ? REQ_WRITE : REQ_PREDICT;
    it.element_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                    : 4'($urandom_range(0, 12));
    it.element_value = rand_q();
    it.force_x = rand_q(); it.force_y = rand_q(); it.force_z = rand_q();
    it.torque_x = rand_q(); it.torque_y = rand_q(); it.torque_z = rand_q();
    it.step_time = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    it.status_flags = 5'($urandom);
    return it;
  endfunction

  // Result side: random stall per item, compare with the oldest expectation.
  initial begin : result_side
    int gap;
    res_t want;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk iff res_valid);
      if (pending_elems.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected element idx=%0d val=%0d",
            res.out_index, res.out_value);
      end else begin
        want = pending_elems.pop_front();
        if (res !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("element mismatch: exp idx=%0d val=%0d last=%0b, got idx=%0d val=%0d last=%0b",
                want.out_index, want.out_value, want.out_last,
                res.out_index, res.out_value, res.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("rigid_body_state_predict_tb: done, errors");
      $finish;
    end
  end

  // Valid stays high into the next item when no idle cycles are drawn.
  task automatic send_item(input req_t it);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    @(posedge clk iff !req_stall);
    predict_step(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic signed [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk iff cfg_ready);
    reg_mdl[idx] = val;
  endtask

  // Writes emit nothing, so wait out a full predict run before touching registers.
  task automatic drain();
    req_valid <= 1'b0;
    wait (pending_elems.size() == 0);
    repeat (500) @(posedge clk);
  endtask

  typedef struct {
    req_t it;
    bit   typed;
    int   elem;
    logic signed [31:0] val;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic req_t wr_item(input int idx, input logic signed [31:0] v);
    req_t it;
    it = '0;
    it.req_type = REQ_WRITE;
    it.element_index = 4'(idx);
    it.element_value = v;
    return it;
  endfunction

  function automatic req_t pr_item(input logic signed [31:0] fv,
      input logic signed [31:0] tv, input logic [15:0] dt, input logic [4:0] fl);
    req_t it;
    it = '0;
    it.req_type = REQ_PREDICT;
    it.force_x = fv; it.force_y = fv; it.force_z = fv;
    it.torque_x = tv; it.torque_y = tv; it.torque_z = tv;
    it.step_time = dt;
    it.status_flags = fl;
    return it;
  endfunction

  initial begin : stimulus
    logic [2:0] ri;
    res_t peek;
    for (int i = 0; i < NSTATE; i++) state_mdl[i] = '0;
    for (int i = 0; i < CFG_NUM; i++) reg_mdl[i] = CFG_RESET[i];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset with zero step the state stays zero; element 0 is typed in.
    dir_rows.push_back('{pr_item(0, 0, 16'd0, 5'd0), 1'b1, 0, 32'sd0});
    dir_rows.push_back('{pr_item(MAXV, MAXV, 16'hffff, 5'd31), 1'b0, 0, 0});
    dir_rows.push_back('{pr_item(MINV, MINV, 16'hffff, 5'd1), 1'b0, 0, 0});
    dir_rows.push_back('{wr_item(3, 32'sd65536), 1'b0, 0, 0});
    dir_rows.push_back('{wr_item(13, MAXV), 1'b0, 0, 0});
    dir_rows.push_back('{wr_item(15, MINV), 1'b0, 0, 0});
    for (int i = 0; i < NSTATE; i++)
      dir_rows.push_back('{wr_item(i, (i % 2) ? MAXV : MINV), 1'b0, 0, 0});
    dir_rows.push_back('{pr_item(MAXV, MINV, 16'hffff, 5'd2), 1'b0, 0, 0});
    dir_rows.push_back('{pr_item(32'sd65536, 32'sd65536, 16'd655, 5'd4), 1'b0, 0, 0});
    dir_rows.push_back('{pr_item(-32'sd65536, 32'sd0, 16'd1, 5'd16), 1'b0, 0, 0});
    dir_rows.push_back('{pr_item(32'sd0, -32'sd1, 16'd32768, 5'd8), 1'b0, 0, 0});

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].typed) begin
        peek = pending_elems[dir_rows[i].elem];
        if (peek.out_value !== dir_rows[i].val) begin
          mismatches++;
          if (mismatches <= 10) $display("typed row %0d: exp %0d model %0d",
              i, dir_rows[i].val, peek.out_value);
        end
      end
    end

    for (int phase = 0; phase < 5; phase++) begin
      drain();
      for (int k = 0; k < CFG_NUM; k++) begin
        ri = 3'(k);
        case (phase)
          0: write_reg(ri, MAXV);
          1: write_reg(ri, MINV);
          2: write_reg(ri, 32'($signed($urandom_range(0, 262144)) - 131072));
          3: write_reg(ri, rand_q());
          default: write_reg(ri, CFG_RESET[k]);
        endcase
      end
      cfg_valid <= 1'b0;
      for (int j = 0; j < 30; j++) send_item(rand_item());
    end

    req_valid <= 1'b0;
    wait (pending_elems.size() == 0);
    repeat (500) @(posedge clk);
    if (mismatches == 0) $display("rigid_body_state_predict_tb: done, clean");
    else $display("rigid_body_state_predict_tb: done, errors");
    $finish;
  end
endmodule
